### design/dqu_pkg.sv
// ----------------------------------------------------------------------------
// dqu_pkg
// Shared codes, defaults and the cell command type for the deque unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dqu_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WORD_W    = 32;
    localparam int OP_W      = 3;
    localparam int ST_W      = 2;

    localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH   = 3'd1;
    localparam logic [OP_W-1:0] OP_VIEW   = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_SWAP   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_REFUSED = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY   = 2'd3;

    typedef struct packed {
        logic shl;   // take word from right neighbor
        logic shr;   // take word from left neighbor
        logic wr;    // cell at index == count loads the write word
    } t_cell_cmd;

endpackage

`default_nettype wire

### design/dqu_cell.sv
// ----------------------------------------------------------------------------
// dqu_cell
// One storage cell of the deque chain: holds a word, shifts left or right,
// or loads the write word when its index matches the fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module dqu_cell import dqu_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IDX   = 0,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic                     i_clk,
    input  wire t_cell_cmd                i_cmd,
    input  wire logic [CNT_W-1:0]         i_count,
    input  wire logic signed [WORD_W-1:0] i_wr_data,
    input  wire logic signed [WORD_W-1:0] i_left,
    input  wire logic signed [WORD_W-1:0] i_right,
    output logic signed [WORD_W-1:0]      o_data
);

    logic signed [WORD_W-1:0] r_data;
    logic signed [WORD_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_cmd.shl) begin
            n_data = i_right;
        end else if (i_cmd.shr) begin
            n_data = i_left;
        end else if (i_cmd.wr && (i_count == CNT_W'(IDX))) begin
            n_data = i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

### design/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded deque of signed 32-bit words held front-aligned in a chain of
// cells. View rotates the whole chain once, swap twice, through a fixed tap.
//
//   channel | valid / ready             | words
//   --------+---------------------------+------------------------------
//   in      | i_in_valid / o_in_ready   | i_op, i_value, i_side
//   out     | o_out_valid / i_out_ready | o_data_out, o_status, o_last
//
// Create, push, clear, swap on fewer than two entries and unused ops finish
// on accept. View makes one chain rotation after accept and can be held by
// output stalls.
// Swap on two or more entries makes two chain rotations after accept.
// Synchronous reset empties the queue; cell contents are not cleared.
// Input is held off while a rotation runs or the output word is not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_unit import dqu_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [OP_W-1:0]          i_op,
    input  wire logic signed [WORD_W-1:0] i_value,
    input  wire logic                     i_side,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic signed [WORD_W-1:0]      o_data_out,
    output logic [ST_W-1:0]               o_status,
    output logic                          o_last
);

    localparam int CW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_VIEW  = 2'd1;
    localparam logic [1:0] S_SWAP1 = 2'd2;
    localparam logic [1:0] S_SWAP2 = 2'd3;

    logic [1:0]               r_state, n_state;
    logic [CW-1:0]            r_step, n_step;
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_side, n_side;
    logic signed [WORD_W-1:0] r_first, n_first;
    logic signed [WORD_W-1:0] r_lastw, n_lastw;

    logic                     r_out_valid, n_out_valid;
    logic signed [WORD_W-1:0] r_out_data, n_out_data;
    logic [ST_W-1:0]          r_out_status, n_out_status;
    logic                     r_out_last, n_out_last;

    logic signed [WORD_W-1:0] w_cell [DEPTH];
    logic signed [WORD_W-1:0] w_left_in;
    logic signed [WORD_W-1:0] w_right_in;
    t_cell_cmd                w_cmd;

    logic             w_out_load;
    logic             w_accept;
    logic [CNT_W-1:0] w_step_ext;
    logic             w_step_end;
    logic             w_front_emit;
    logic             w_back_emit;
    logic             w_is_last_pos;
    logic             w_full;

    assign w_out_load    = !r_out_valid || i_out_ready;
    assign o_in_ready    = (r_state == S_IDLE) && w_out_load;
    assign w_accept      = i_in_valid && o_in_ready;
    assign w_step_ext    = CNT_W'(r_step);
    assign w_step_end    = (r_step == CW'(DEPTH - 1));
    assign w_front_emit  = (w_step_ext < r_count);
    assign w_back_emit   = ((CNT_W + 1)'(r_step) + (CNT_W + 1)'(r_count))
                           >= (CNT_W + 1)'(DEPTH);
    assign w_is_last_pos = ((w_step_ext + CNT_W'(1)) == r_count);
    assign w_full        = (r_count == CNT_W'(DEPTH));

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [WORD_W-1:0] w_l;
            logic signed [WORD_W-1:0] w_r;
            if (g == 0) begin : g_lend
                assign w_l = w_left_in;
            end else begin : g_lmid
                assign w_l = w_cell[g-1];
            end
            if (g == DEPTH - 1) begin : g_rend
                assign w_r = w_right_in;
            end else begin : g_rmid
                assign w_r = w_cell[g+1];
            end
            dqu_cell #(
                .DEPTH (DEPTH),
                .IDX   (g)
            ) u_cell (
                .i_clk     (i_clk),
                .i_cmd     (w_cmd),
                .i_count   (r_count),
                .i_wr_data (i_value),
                .i_left    (w_l),
                .i_right   (w_r),
                .o_data    (w_cell[g])
            );
        end
    endgenerate

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_count      = r_count;
        n_side       = r_side;
        n_first      = r_first;
        n_lastw      = r_lastw;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        w_cmd        = '0;
        w_left_in    = i_value;
        w_right_in   = w_cell[0];

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_op) inside
                        OP_CREATE, OP_PUSH: begin
                            n_out_valid = 1'b1;
                            n_out_last  = 1'b1;
                            if (i_op == OP_CREATE && r_count != '0) begin
                                n_out_data   = '0;
                                n_out_status = ST_REFUSED;
                            end else if (r_count == '0) begin
                                w_cmd.wr     = 1'b1;
                                n_count      = CNT_W'(1);
                                n_out_data   = i_value;
                                n_out_status = ST_OK;
                            end else if (w_full) begin
                                n_out_data   = '0;
                                n_out_status = ST_FULL;
                            end else begin
                                if (i_side) begin
                                    w_cmd.wr = 1'b1;
                                end else begin
                                    w_cmd.shr = 1'b1;
                                end
                                n_count      = r_count + CNT_W'(1);
                                n_out_data   = i_value;
                                n_out_status = ST_OK;
                            end
                        end
                        OP_VIEW: begin
                            if (r_count == '0) begin
                                n_out_valid  = 1'b1;
                                n_out_data   = '0;
                                n_out_status = ST_EMPTY;
                                n_out_last   = 1'b1;
                            end else begin
                                n_state = S_VIEW;
                                n_step  = '0;
                                n_side  = i_side;
                            end
                        end
                        OP_CLEAR: begin
                            n_count      = '0;
                            n_out_valid  = 1'b1;
                            n_out_data   = '0;
                            n_out_status = ST_OK;
                            n_out_last   = 1'b1;
                        end
                        OP_SWAP: begin
                            n_out_valid  = 1'b1;
                            n_out_data   = '0;
                            n_out_last   = 1'b1;
                            n_out_status = (r_count == '0) ? ST_EMPTY : ST_OK;
                            if (r_count > CNT_W'(1)) begin
                                n_state = S_SWAP1;
                                n_step  = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_VIEW: begin
                if (!r_side) begin
                    if (!w_front_emit || w_out_load) begin
                        w_cmd.shl = 1'b1;
                        n_step    = r_step + CW'(1);
                        if (w_front_emit) begin
                            n_out_valid  = 1'b1;
                            n_out_data   = w_cell[0];
                            n_out_status = ST_OK;
                            n_out_last   = w_is_last_pos;
                        end
                        if (w_step_end) begin
                            n_state = S_IDLE;
                            n_step  = '0;
                        end
                    end
                end else begin
                    w_left_in = w_cell[DEPTH-1];
                    if (!w_back_emit || w_out_load) begin
                        w_cmd.shr = 1'b1;
                        n_step    = r_step + CW'(1);
                        if (w_back_emit) begin
                            n_out_valid  = 1'b1;
                            n_out_data   = w_cell[DEPTH-1];
                            n_out_status = ST_OK;
                            n_out_last   = w_step_end;
                        end
                        if (w_step_end) begin
                            n_state = S_IDLE;
                            n_step  = '0;
                        end
                    end
                end
            end
            S_SWAP1: begin
                w_cmd.shl = 1'b1;
                n_step    = r_step + CW'(1);
                if (r_step == '0) begin
                    n_first = w_cell[0];
                end
                if (w_is_last_pos) begin
                    n_lastw = w_cell[0];
                end
                if (w_step_end) begin
                    n_state = S_SWAP2;
                    n_step  = '0;
                end
            end
            S_SWAP2: begin
                w_cmd.shl = 1'b1;
                n_step    = r_step + CW'(1);
                if (r_step == '0) begin
                    w_right_in = r_lastw;
                end else if (w_is_last_pos) begin
                    w_right_in = r_first;
                end
                if (w_step_end) begin
                    n_state = S_IDLE;
                    n_step  = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_count     <= '0;
            r_side      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_count     <= n_count;
            r_side      <= n_side;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first      <= n_first;
        r_lastw      <= n_lastw;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_out_data;
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;

endmodule

`default_nettype wire
